// ===== rtl/rbsg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the rounded box span generator.
package rbsg_pkg;

  // Command carried on the input tuser bit
  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  // Span engine phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_CIRCLE = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  // Classification travelling with each queued command
  typedef struct packed {
    cmd_t   cmd;
    phase_t phase;
  } ctrl_t;

  // Configuration register indexes
  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Y = 1'b1;

  localparam int CTRL_W   = $bits(ctrl_t);
  localparam int COLOUR_W = 32;

endpackage

// ===== rtl/rounded_box_span_generator_top.sv =====
`timescale 1ns / 1ps
// Top level of the rounded box span generator.
//
//  channel  | group                    | payload
//  ---------+--------------------------+-----------------------------------------------
//  command  | s_axis_t{valid,ready}    | tuser: command; tdata: box, radius, colour
//  span     | m_axis_t{valid,ready}    | tdata: x, y, length, colour; tlast: last_span
//  config   | cfg_write                | cfg_index selects origin_x / origin_y
//
// One command is taken per cycle and one span leaves per cycle at full flow.
// A command passes three front stages and the queue, then the span engine's
// output register; box setup (tenths and thirds by reciprocal multiply) sets
// the front-end depth.
// rst is synchronous and clears all valid flags, the queue, phase and origins.
// A stalled span output holds its register; the queue and front stages absorb
// further commands until they fill, then s_axis_tready drops.
module rounded_box_span_generator_top #(
  parameter int COORD_BITS  = 12,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_write,
  input  logic                                          cfg_index,
  input  logic [COORD_BITS-1:0]                         cfg_data,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // left_x, top_y, right_x, bottom_y, corner_radius, fill_colour (low bit up)
  input  logic [((5*COORD_BITS+31+7)/8)*8-1:0]          s_axis_tdata,
  // command
  input  logic                                          s_axis_tuser,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // span_x, span_y, span_length, span_colour (low bit up)
  output logic [((3*COORD_BITS+34+7)/8)*8-1:0]          m_axis_tdata,
  output logic                                          m_axis_tlast
);

  localparam int CW     = COORD_BITS;
  localparam int CLW    = rbsg_pkg::COLOUR_W;
  localparam int OUT_W  = ((3*CW+34+7)/8)*8;
  localparam int DATA_W = rbsg_pkg::CTRL_W + 5*CW + 34;

  // Front end to queue
  logic                    fe_valid, fe_ready;
  rbsg_pkg::ctrl_t         fe_ctrl;
  logic [CW-1:0]           fe_w;
  logic signed [CW:0]      fe_h;
  logic [CW-2:0]           fe_rad;
  logic [CW:0]             fe_bx, fe_by;
  logic [CLW-1:0]          fe_colour;

  rbsg_front #(
    .CW (CW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (rbsg_pkg::cmd_t'(s_axis_tuser)),
    .in_left    (s_axis_tdata[0 +: CW]),
    .in_top     (s_axis_tdata[CW +: CW]),
    .in_right   (s_axis_tdata[2*CW +: CW]),
    .in_bottom  (s_axis_tdata[3*CW +: CW]),
    .in_radius  (s_axis_tdata[4*CW +: CW-1]),
    .in_colour  (s_axis_tdata[5*CW-1 +: CLW]),
    .out_valid  (fe_valid),
    .out_ready  (fe_ready),
    .out_ctrl   (fe_ctrl),
    .out_w      (fe_w),
    .out_h      (fe_h),
    .out_rad    (fe_rad),
    .out_base_x (fe_bx),
    .out_base_y (fe_by),
    .out_colour (fe_colour)
  );

  // Queue
  logic                    q_valid, q_ready;
  logic [DATA_W-1:0]       q_data;
  rbsg_pkg::ctrl_t         q_ctrl;
  logic [CW-1:0]           q_w;
  logic signed [CW:0]      q_h;
  logic [CW-2:0]           q_rad;
  logic [CW:0]             q_bx, q_by;
  logic [CLW-1:0]          q_colour;

  rbsg_fifo #(
    .DATA_W (DATA_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fe_valid),
    .in_ready  (fe_ready),
    .in_data   ({fe_ctrl, fe_w, fe_h, fe_rad, fe_bx, fe_by, fe_colour}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  assign {q_ctrl, q_w, q_h, q_rad, q_bx, q_by, q_colour} = q_data;

  // Span engine
  logic [CW:0]     sp_x, sp_y;
  logic [CW-1:0]   sp_len;
  logic [CLW-1:0]  sp_colour;

  rbsg_span_engine #(
    .CW (CW)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_ctrl    (q_ctrl),
    .in_w       (q_w),
    .in_h       (q_h),
    .in_rad     (q_rad),
    .in_base_x  (q_bx),
    .in_base_y  (q_by),
    .in_colour  (q_colour),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_x      (sp_x),
    .out_y      (sp_y),
    .out_len    (sp_len),
    .out_colour (sp_colour),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({sp_colour, sp_len, sp_y, sp_x});

endmodule

// ===== rtl/rbsg_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts commands and works out box setup over three stages.
module rbsg_front #(
  parameter int CW = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [CW-1:0]                     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rbsg_pkg::cmd_t                    in_cmd,
  input  logic [CW-1:0]                     in_left,
  input  logic [CW-1:0]                     in_top,
  input  logic [CW-1:0]                     in_right,
  input  logic [CW-1:0]                     in_bottom,
  input  logic [CW-2:0]                     in_radius,
  input  logic [rbsg_pkg::COLOUR_W-1:0]     in_colour,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rbsg_pkg::ctrl_t                   out_ctrl,
  output logic [CW-1:0]                     out_w,
  output logic signed [CW:0]                out_h,
  output logic [CW-2:0]                     out_rad,
  output logic [CW:0]                       out_base_x,
  output logic [CW:0]                       out_base_y,
  output logic [rbsg_pkg::COLOUR_W-1:0]     out_colour
);

  // Reciprocal constants for exact floor division of CW-bit values
  localparam int            K10 = CW + 4;
  localparam logic [CW:0]   M10 = (CW+1)'(((64'd1 << K10) + 64'd9) / 64'd10);
  localparam int            K3  = CW + 2;
  localparam logic [CW:0]   M3  = (CW+1)'(((64'd1 << K3) + 64'd2) / 64'd3);
  localparam int            PW  = 2 * CW + 1;

  // Origin registers
  logic [CW-1:0] origin_x, origin_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rbsg_pkg::CFG_ORIGIN_X: origin_x <= cfg_data;
        rbsg_pkg::CFG_ORIGIN_Y: origin_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage loads when it is empty or its successor moves
  logic a_valid, b_valid, c_valid;
  logic a_ready, b_ready, c_ready;

  assign c_ready  = !c_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // Stage A: captured transaction
  rbsg_pkg::cmd_t               a_cmd;
  logic [CW-1:0]                a_left, a_top, a_right, a_bottom;
  logic [CW-2:0]                a_radius;
  logic [rbsg_pkg::COLOUR_W-1:0] a_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_cmd    <= in_cmd;
      a_left   <= in_left;
      a_top    <= in_top;
      a_right  <= in_right;
      a_bottom <= in_bottom;
      a_radius <= in_radius;
      a_colour <= in_colour;
    end
  end

  // Width clamp, height adjust and base position
  logic signed [CW:0] w_raw, h_raw, h_adj;
  logic [CW-1:0]      w_clamp;
  logic               h_small;
  logic [CW:0]        bx_sum, by_sum;

  assign w_raw   = $signed({1'b0, a_right}) - $signed({1'b0, a_left});
  assign w_clamp = w_raw[CW] ? '0 : w_raw[CW-1:0];
  assign h_raw   = $signed({1'b0, a_bottom}) - $signed({1'b0, a_top});
  assign h_small = h_raw[CW] || (h_raw[CW-1:1] == '0);
  assign bx_sum  = {1'b0, origin_x} + {1'b0, a_left};
  assign by_sum  = {1'b0, origin_y} + {1'b0, a_top};

  always_comb begin
    h_adj = h_raw;
    if (a_radius != '0) begin
      h_adj = h_small ? $signed((CW+1)'(1)) : h_raw - $signed((CW+1)'(1));
    end
  end

  // Stage B: width, height and base
  rbsg_pkg::cmd_t               b_cmd;
  logic [CW-1:0]                b_w;
  logic signed [CW:0]           b_h;
  logic [CW-2:0]                b_rad;
  logic [CW:0]                  b_base_x, b_base_y;
  logic [rbsg_pkg::COLOUR_W-1:0] b_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_cmd    <= a_cmd;
      b_w      <= w_clamp;
      b_h      <= h_adj;
      b_rad    <= a_radius;
      b_base_x <= bx_sum;
      b_base_y <= by_sum;
      b_colour <= a_colour;
    end
  end

  // Tenths of width and height, and the oversize test
  logic [CW-1:0] b_hu;
  logic [PW-1:0] p_w10, p_h10;
  logic [CW-4:0] w_tenth, h_tenth;
  logic          replace;

  assign b_hu    = b_h[CW-1:0];
  assign p_w10   = PW'(b_w) * PW'(M10);
  assign p_h10   = PW'(b_hu) * PW'(M10);
  assign w_tenth = p_w10[PW-1:K10];
  assign h_tenth = p_h10[PW-1:K10];
  assign replace = (b_rad == (CW-1)'(1)) || (b_rad > b_w[CW-1:1]) || (b_rad > b_hu[CW-1:1]);

  // Stage C: candidates ready for the final radius choice
  rbsg_pkg::cmd_t               c_cmd;
  logic [CW-1:0]                c_w;
  logic signed [CW:0]           c_h;
  logic [CW-2:0]                c_rad;
  logic [CW-4:0]                c_a, c_c;
  logic                         c_replace;
  logic [CW:0]                  c_base_x, c_base_y;
  logic [rbsg_pkg::COLOUR_W-1:0] c_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_cmd     <= b_cmd;
      c_w       <= b_w;
      c_h       <= b_h;
      c_rad     <= b_rad;
      c_a       <= w_tenth;
      c_c       <= h_tenth;
      c_replace <= replace;
      c_base_x  <= b_base_x;
      c_base_y  <= b_base_y;
      c_colour  <= b_colour;
    end
  end

  // Pick the larger tenth, cap it at a third of the other side
  logic          sel_w;
  logic [CW-1:0] num;
  logic [PW-1:0] p_3;
  logic [CW-2:0] third, cand, rad_x, rad_final;

  assign sel_w     = c_a > c_c;
  assign num       = sel_w ? c_h[CW-1:0] : c_w;
  assign p_3       = PW'(num) * PW'(M3);
  assign third     = p_3[PW-1:K3];
  assign cand      = sel_w ? (CW-1)'(c_a) : (CW-1)'(c_c);
  assign rad_x     = (cand > third) ? third : cand;
  assign rad_final = (c_rad == '0) ? '0 : (c_replace ? rad_x : c_rad);

  // Classify and hand over to the queue
  always_comb begin
    out_ctrl.cmd = c_cmd;
    if (c_rad != '0) begin
      out_ctrl.phase = rbsg_pkg::PH_CIRCLE;
    end else if (!c_h[CW] && (c_h != '0)) begin
      out_ctrl.phase = rbsg_pkg::PH_BODY;
    end else begin
      out_ctrl.phase = rbsg_pkg::PH_IDLE;
    end
  end

  assign out_valid  = c_valid;
  assign out_w      = c_w;
  assign out_h      = c_h;
  assign out_rad    = rad_final;
  assign out_base_x = c_base_x;
  assign out_base_y = c_base_y;
  assign out_colour = c_colour;

endmodule

// ===== rtl/rbsg_fifo.sv =====
`timescale 1ns / 1ps
// Short first-word-fall-through queue between front end and span engine.
module rbsg_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  // DEPTH must be a power of two so the pointers wrap on their own; the block itself does not enforce it
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entries [DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push, pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue occupancy beyond depth");

  a_count_push: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue occupancy did not follow a push");
`endif

endmodule

// ===== rtl/rbsg_span_engine.sv =====
`timescale 1ns / 1ps
// Back end: walks the corner circle and body rows, one span per advance while a box is active.
module rbsg_span_engine #(
  parameter int CW = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rbsg_pkg::ctrl_t               in_ctrl,
  input  logic [CW-1:0]                 in_w,
  input  logic signed [CW:0]            in_h,
  input  logic [CW-2:0]                 in_rad,
  input  logic [CW:0]                   in_base_x,
  input  logic [CW:0]                   in_base_y,
  input  logic [rbsg_pkg::COLOUR_W-1:0] in_colour,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CW:0]                   out_x,
  output logic [CW:0]                   out_y,
  output logic [CW-1:0]                 out_len,
  output logic [rbsg_pkg::COLOUR_W-1:0] out_colour,
  output logic                          out_last
);

  localparam int SW = CW + 2;
  localparam int LW = CW + 3;

  // Box state
  rbsg_pkg::phase_t             phase, phase_next;
  logic [1:0]                   quarter, quarter_next;
  logic signed [CW:0]           step_x, step_x_next;
  logic signed [CW:0]           step_y, step_y_next;
  logic signed [SW-1:0]         decision, decision_next;
  logic signed [CW:0]           body_row, body_row_next;
  logic [CW-2:0]                rad_used;
  logic [CW-1:0]                box_w;
  logic signed [CW:0]           box_h;
  logic [CW:0]                  base_x, base_y;
  logic [rbsg_pkg::COLOUR_W-1:0] colour;

  logic pop, is_start, emit;

  assign is_start = (in_ctrl.cmd == rbsg_pkg::CMD_START);
  assign in_ready = is_start || (phase == rbsg_pkg::PH_IDLE) || !out_valid || out_ready;
  assign pop      = in_valid && in_ready;
  assign emit     = pop && !is_start && (phase != rbsg_pkg::PH_IDLE);

  // Span for the current position
  logic signed [SW-1:0] rad_s, h_s, rx, ry, dx, dy, r_sel;
  logic signed [LW-1:0] len_s;
  logic [CW:0]          span_x, span_y;
  logic [CW-1:0]        span_len;

  assign rad_s = $signed(SW'(rad_used));
  assign h_s   = SW'(box_h);
  assign rx    = rad_s - SW'(step_x);
  assign ry    = rad_s - SW'(step_y);

  always_comb begin
    dx    = '0;
    dy    = SW'(body_row);
    r_sel = '0;
    if (phase == rbsg_pkg::PH_CIRCLE) begin
      case (quarter)
        2'd0: begin
          dx = rx; dy = h_s - ry; r_sel = rx;
        end
        2'd1: begin
          dx = rx; dy = ry; r_sel = rx;
        end
        2'd2: begin
          dx = ry; dy = rx; r_sel = ry;
        end
        default: begin
          dx = ry; dy = h_s - rx; r_sel = ry;
        end
      endcase
    end
  end

  assign len_s    = $signed(LW'(box_w)) - (LW'(r_sel) <<< 1);
  assign span_len = len_s[LW-1] ? '0 : len_s[CW-1:0];
  assign span_x   = base_x + dx[CW:0];
  assign span_y   = base_y + dy[CW:0];

  // Midpoint step candidates
  logic signed [CW:0]   sx_inc, sy_dec;
  logic signed [SW-1:0] d_inside, d_outside;

  assign sx_inc    = step_x + $signed((CW+1)'(1));
  assign sy_dec    = step_y - $signed((CW+1)'(1));
  assign d_inside  = decision + (SW'(sx_inc) <<< 1) - $signed(SW'(1));
  assign d_outside = decision + ((SW'(sx_inc) - SW'(step_y)) <<< 1);

  // Next state
  always_comb begin
    phase_next    = phase;
    quarter_next  = quarter;
    step_x_next   = step_x;
    step_y_next   = step_y;
    decision_next = decision;
    body_row_next = body_row;
    if (pop) begin
      if (is_start) begin
        phase_next    = in_ctrl.phase;
        quarter_next  = '0;
        step_x_next   = '0;
        step_y_next   = $signed((CW+1)'(in_rad));
        decision_next = $signed(SW'(1)) - $signed(SW'(in_rad));
        body_row_next = '0;
      end else begin
        case (phase)
          rbsg_pkg::PH_CIRCLE: begin
            quarter_next = quarter + 2'd1;
            if (quarter == 2'd3) begin
              step_x_next = sx_inc;
              if (decision[SW-1]) begin
                decision_next = d_inside;
              end else begin
                decision_next = d_outside;
                step_y_next   = sy_dec;
              end
              if (sx_inc > (decision[SW-1] ? step_y : sy_dec)) begin
                body_row_next = $signed((CW+1)'(rad_used));
                phase_next    = (rad_s < h_s - rad_s) ? rbsg_pkg::PH_BODY : rbsg_pkg::PH_IDLE;
              end
            end
          end
          rbsg_pkg::PH_BODY: begin
            body_row_next = body_row + $signed((CW+1)'(1));
            if (SW'(body_row_next) >= h_s - rad_s) begin
              phase_next = rbsg_pkg::PH_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= rbsg_pkg::PH_IDLE;
      quarter <= '0;
    end else begin
      phase   <= phase_next;
      quarter <= quarter_next;
    end
  end

  // Walk registers and box latch
  always_ff @(posedge clk) begin
    step_x   <= step_x_next;
    step_y   <= step_y_next;
    decision <= decision_next;
    body_row <= body_row_next;
    if (pop && is_start) begin
      rad_used <= in_rad;
      box_w    <= in_w;
      box_h    <= in_h;
      base_x   <= in_base_x;
      base_y   <= in_base_y;
      colour   <= in_colour;
    end
  end

  // Output register: load a span, drop it once taken
  logic last_next;
  assign last_next = (phase_next == rbsg_pkg::PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x      <= span_x;
      out_y      <= span_y;
      out_len    <= span_len;
      out_colour <= colour;
      out_last   <= last_next;
    end
  end

`ifndef SYNTHESIS
  a_quarter_rest: assert property (@(posedge clk) disable iff (rst)
    (phase != rbsg_pkg::PH_CIRCLE) |-> (quarter == '0))
    else $error("quarter index moved outside the circle phase");

  a_body_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == rbsg_pkg::PH_BODY) |-> (SW'(body_row) < h_s - rad_s))
    else $error("body row past the end of the box");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && last_next) |=> (phase == rbsg_pkg::PH_IDLE))
    else $error("final span issued while the box is still active");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the rounded box span generator: directed table, then random boxes.
module testbench;

  localparam int COORD_BITS = 12;
  localparam int IN_W       = ((5*COORD_BITS+31+7)/8)*8;
  localparam int OUT_W      = ((3*COORD_BITS+34+7)/8)*8;
  localparam int STALL_CAP  = 2000;
  localparam int SETTLE     = 12;

  // One command as it travels on the input stream
  typedef struct packed {
    rbsg_pkg::cmd_t cmd;
    logic [11:0]    left_x;
    logic [11:0]    top_y;
    logic [11:0]    right_x;
    logic [11:0]    bottom_y;
    logic [10:0]    radius;
    logic [31:0]    colour;
  } box_cmd_t;

  // One span as it leaves on the output stream
  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic [11:0] len;
    logic [31:0] colour;
    logic        last;
  } span_t;

  typedef struct packed {
    box_cmd_t item;
    bit       typed;
    span_t    want;
  } dir_row_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic             cfg_index = rbsg_pkg::CFG_ORIGIN_X;
  logic [11:0]      cfg_data = '0;
  logic             s_valid = 1'b0;
  logic             s_ready;
  logic [IN_W-1:0]  s_data = '0;
  logic             s_user = rbsg_pkg::CMD_START;
  logic             m_valid;
  logic             m_ready = 1'b0;
  logic [OUT_W-1:0] m_data;
  logic             m_last;

  rounded_box_span_generator_top #(.COORD_BITS(COORD_BITS)) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Span engine mirror: origins, box geometry and midpoint circle state
  logic [11:0]      org_x = '0;
  logic [11:0]      org_y = '0;
  rbsg_pkg::phase_t ph = rbsg_pkg::PH_IDLE;
  logic [1:0]       quarter = '0;
  int               sx = 0, sy = 0, dec = 0, rad_used = 0;
  int               bw = 0, bh = 0, brow = 0;
  logic [12:0]      bx = '0, by = '0;
  logic [31:0]      col = '0;

  span_t       span_queue[$];
  int          mismatches = 0;
  bit          steady = 1'b0;
  dir_row_t    dir_rows[$];

  function automatic span_t make_span(int dx, int dy, int len);
    span_t s;
    int    px, py;
    px = int'(bx) + dx;
    py = int'(by) + dy;
    s.x      = px[12:0];
    s.y      = py[12:0];
    s.len    = (len < 0) ? 12'd0 : len[11:0];
    s.colour = col;
    s.last   = 1'b0;
    return s;
  endfunction

  // Latch a new box; a box in progress is dropped
  function automatic void latch_box(box_cmd_t c);
    int w, h, rad, sum;
    w   = int'(c.right_x) - int'(c.left_x);
    h   = int'(c.bottom_y) - int'(c.top_y);
    rad = int'(c.radius);
    col = c.colour;
    sum = int'(org_x) + int'(c.left_x);
    bx  = sum[12:0];
    sum = int'(org_y) + int'(c.top_y);
    by  = sum[12:0];
    if (w < 0) w = 0;
    brow = 0;
    if (rad != 0) begin
      h = h - 1;
      if (h <= 0) h = 1;
      // swap an unusable radius for a tenth of the longer side, capped at a third
      if (rad == 1 || rad > w / 2 || rad > h / 2) begin
        if (w / 10 > h / 10) rad = (w / 10 > h / 3) ? h / 3 : w / 10;
        else rad = (h / 10 > w / 3) ? w / 3 : h / 10;
      end
      ph      = rbsg_pkg::PH_CIRCLE;
      quarter = '0;
      sx      = 0;
      sy      = rad;
      dec     = 1 - rad;
    end else begin
      ph = (h > 0) ? rbsg_pkg::PH_BODY : rbsg_pkg::PH_IDLE;
    end
    rad_used = rad;
    bw       = w;
    bh       = h;
  endfunction

  // Advance the engine by one span; returns 0 when idle
  function automatic bit next_span(output span_t s);
    int rx, ry;
    s = '0;
    if (ph == rbsg_pkg::PH_IDLE) return 1'b0;
    if (ph == rbsg_pkg::PH_CIRCLE) begin
      rx = rad_used - sx;
      ry = rad_used - sy;
      case (quarter)
        2'd0:    s = make_span(rx, bh - ry, bw - 2 * rx);
        2'd1:    s = make_span(rx, ry, bw - 2 * rx);
        2'd2:    s = make_span(ry, rx, bw - 2 * ry);
        default: s = make_span(ry, bh - rx, bw - 2 * ry);
      endcase
      quarter = quarter + 2'd1;
      if (quarter == 2'd0) begin
        sx++;
        if (dec < 0) begin
          dec += 2 * sx - 1;
        end else begin
          dec += 2 * (sx - sy);
          sy--;
        end
        if (sx > sy) begin
          brow = rad_used;
          ph   = (brow < bh - rad_used) ? rbsg_pkg::PH_BODY : rbsg_pkg::PH_IDLE;
        end
      end
    end else begin
      s = make_span(0, brow, bw);
      brow++;
      if (brow >= bh - rad_used) ph = rbsg_pkg::PH_IDLE;
    end
    s.last = (ph == rbsg_pkg::PH_IDLE);
    return 1'b1;
  endfunction

  function automatic box_cmd_t any_fields(rbsg_pkg::cmd_t c);
    box_cmd_t it;
    it.cmd      = c;
    it.left_x   = 12'($urandom_range(0, 4095));
    it.top_y    = 12'($urandom_range(0, 4095));
    it.right_x  = 12'($urandom_range(0, 4095));
    it.bottom_y = 12'($urandom_range(0, 4095));
    it.radius   = 11'($urandom_range(0, 2047));
    it.colour   = $urandom();
    return it;
  endfunction

  function automatic dir_row_t dir_entry(rbsg_pkg::cmd_t c, int l, int t, int r, int b,
                                         int rad, logic [31:0] colour, bit typed,
                                         int ex, int ey, int elen, bit elast);
    dir_row_t e;
    e.item        = '{cmd: c, left_x: l[11:0], top_y: t[11:0], right_x: r[11:0],
                      bottom_y: b[11:0], radius: rad[10:0], colour: colour};
    e.typed       = typed;
    e.want.x      = ex[12:0];
    e.want.y      = ey[12:0];
    e.want.len    = elen[11:0];
    e.want.colour = colour;
    e.want.last   = elast;
    return e;
  endfunction

  // Present one command, wait for its transaction, then latch its box or predict its span
  task automatic send_item(box_cmd_t it, bit typed, span_t want);
    int    gap;
    span_t s;
    gap = steady ? 0 : int'($urandom_range(0, 3));
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= it.cmd;
    s_data  <= {it.colour, it.radius, it.bottom_y, it.right_x, it.top_y, it.left_x};
    do @(posedge clk); while (!s_ready);
    if (it.cmd == rbsg_pkg::CMD_START) begin
      latch_box(it);
    end else if (next_span(s)) begin
      span_queue.push_back(typed ? want : s);
    end
  endtask

  task automatic send(box_cmd_t it);
    send_item(it, 1'b0, '0);
  endtask

  // Hold the sender until every span is out, then let the pipeline settle
  task automatic drain();
    s_valid <= 1'b0;
    while (span_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_origin(logic [11:0] ox, logic [11:0] oy);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= rbsg_pkg::CFG_ORIGIN_X;
    cfg_data  <= ox;
    @(posedge clk);
    org_x = ox;
    cfg_index <= rbsg_pkg::CFG_ORIGIN_Y;
    cfg_data  <= oy;
    @(posedge clk);
    org_y = oy;
    cfg_write <= 1'b0;
  endtask

  // Random boxes: mostly complete small boxes, some abandoned, some noise
  task automatic run_phase(int n);
    int       done, kind, span_w, span_h, extra;
    box_cmd_t it;
    done = 0;
    while (done < n) begin
      kind   = int'($urandom_range(0, 99));
      steady = ($urandom_range(0, 7) == 0);
      if (kind < 72) begin
        it     = any_fields(rbsg_pkg::CMD_START);
        span_w = (kind < 3) ? int'($urandom_range(0, 300)) : int'($urandom_range(0, 40));
        span_h = (kind < 3) ? int'($urandom_range(0, 300)) : int'($urandom_range(0, 40));
        if ($urandom_range(0, 7) == 0) span_w = -int'($urandom_range(1, 40));
        it.right_x  = it.left_x + span_w[11:0];
        it.bottom_y = it.top_y + span_h[11:0];
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4: it.radius = '0;
          5, 6:          it.radius = 11'd1;
          7, 8, 9:       it.radius = 11'($urandom_range(0, 2047));
          default:       it.radius = 11'($urandom_range(2, 20));
        endcase
        send(it);
        done++;
        while (ph != rbsg_pkg::PH_IDLE) begin
          send(any_fields(rbsg_pkg::CMD_ADVANCE));
          done++;
        end
        extra = int'($urandom_range(0, 3));
        repeat (extra) send(any_fields(rbsg_pkg::CMD_ADVANCE));
      end else if (kind < 87) begin
        send(any_fields(rbsg_pkg::CMD_START));
        done++;
        extra = int'($urandom_range(0, 30));
        repeat (extra) begin
          if (ph != rbsg_pkg::PH_IDLE) done++;
          send(any_fields(rbsg_pkg::CMD_ADVANCE));
        end
      end else begin
        it = any_fields($urandom_range(0, 1) ? rbsg_pkg::CMD_ADVANCE : rbsg_pkg::CMD_START);
        if (it.cmd == rbsg_pkg::CMD_START || ph != rbsg_pkg::PH_IDLE) done++;
        send(it);
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    // advance while idle, plain box, negative width, empty box, radius of one,
    // oversized radius at the far corner, radius above half the side
    dir_rows.push_back(dir_entry(rbsg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0, 0,
                                 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_entry(rbsg_pkg::CMD_START, 10, 20, 14, 22, 0, 32'hFFFF_FFFF,
                                 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_entry(rbsg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF,
                                 1, 10, 20, 4, 0));
    dir_rows.push_back(dir_entry(rbsg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF,
                                 1, 10, 21, 4, 1));
    dir_rows.push_back(dir_entry(rbsg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0, 0,
                                 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_entry(rbsg_pkg::CMD_START, 100, 0, 50, 3, 0, 0,
                                 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_entry(rbsg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0, 0,
                                 1, 100, 0, 0, 0));
    dir_rows.push_back(dir_entry(rbsg_pkg::CMD_START, 0, 5, 10, 5, 0, 32'h1234_5678,
                                 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_entry(rbsg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0, 0,
                                 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_entry(rbsg_pkg::CMD_START, 0, 0, 4095, 4095, 1, 32'hA5A5_A5A5,
                                 0, 0, 0, 0, 0));
    repeat (3) dir_rows.push_back(dir_entry(rbsg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0, 0,
                                            0, 0, 0, 0, 0));
    dir_rows.push_back(dir_entry(rbsg_pkg::CMD_START, 4095, 4095, 4095, 4095, 2047,
                                 32'h5A5A_5A5A, 0, 0, 0, 0, 0));
    repeat (6) dir_rows.push_back(dir_entry(rbsg_pkg::CMD_ADVANCE, 4095, 4095, 4095, 4095,
                                            2047, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    dir_rows.push_back(dir_entry(rbsg_pkg::CMD_START, 0, 0, 20, 21, 2047, 32'h0F0F_0F0F,
                                 0, 0, 0, 0, 0));
    repeat (4) dir_rows.push_back(dir_entry(rbsg_pkg::CMD_ADVANCE, 0, 0, 0, 0, 0, 0,
                                            0, 0, 0, 0, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    set_origin(12'hFFF, 12'hFFF);
    run_phase(380);
    set_origin(12'h000, 12'hFFF);
    run_phase(380);
    set_origin(12'hFFF, 12'h000);
    run_phase(380);
    set_origin(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    run_phase(380);
    set_origin(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    run_phase(380);

    drain();
    if (mismatches == 0 && span_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Span sink: random back-pressure, compare each transaction with the oldest prediction
  int stall_left = 0;

  always @(posedge clk) begin : span_sink
    span_t got, want;
    string bad;
    int    n;
    if (rst) begin
      m_ready    <= 1'b0;
      stall_left <= 0;
    end else if (m_valid && m_ready) begin
      got.x      = m_data[12:0];
      got.y      = m_data[25:13];
      got.len    = m_data[37:26];
      got.colour = m_data[69:38];
      got.last   = m_last;
      bad        = "";
      if (span_queue.size() == 0) begin
        want = '0;
        bad  = " unexpected";
      end else begin
        want = span_queue.pop_front();
        if (got.x !== want.x) bad = {bad, " x"};
        if (got.y !== want.y) bad = {bad, " y"};
        if (got.len !== want.len) bad = {bad, " length"};
        if (got.colour !== want.colour) bad = {bad, " colour"};
        if (got.last !== want.last) bad = {bad, " last"};
      end
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10)
          $display({"span mismatch (%s) want x=%0d y=%0d len=%0d col=%h last=%0d,",
                    " got x=%0d y=%0d len=%0d col=%h last=%0d"},
                   bad, want.x, want.y, want.len, want.colour, want.last,
                   got.x, got.y, got.len, got.colour, got.last);
      end
      n = steady ? 0 : int'($urandom_range(0, 3));
      if (n == 0) begin
        m_ready <= 1'b1;
      end else begin
        m_ready    <= 1'b0;
        stall_left <= n;
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) m_ready <= 1'b1;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_valid && s_ready) || (m_valid && m_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_CAP) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
